// File: rtl/galois_automorphism_permuter_macros.svh
// Assertion macros shared by the checker of the Galois automorphism permuter.
`ifndef GALOIS_AUTOMORPHISM_PERMUTER_MACROS_SVH
`define GALOIS_AUTOMORPHISM_PERMUTER_MACROS_SVH

// Check a consequent in the cycle after the antecedent, outside reset
`define GAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check a consequent in the same cycle as the antecedent, outside reset
`define GAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/gap_pkg.sv
// Package: field widths, opcodes and control types of the automorphism permuter.
package gap_pkg;

    localparam int OPCODE_W     = 2;
    localparam int POS_W        = 12;
    localparam int COEFF_W      = 64;
    localparam int ROT_W        = 12;
    localparam int CFG_W        = 4;
    localparam int IN_TDATA_W   = 88;  // position + coeff_in + rotation
    localparam int OUT_TDATA_W  = 80;  // coeff_out + out_position, byte padded
    localparam int DEF_MAX_SIZE = 4096;

    localparam logic [CFG_W-1:0] LOG_SIZE_RST = 4'd12;
    localparam logic [CFG_W-1:0] LOG_SIZE_MIN = 4'd2;

    localparam logic [OPCODE_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SELECT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

    // Request to the exponent unit
    typedef struct packed {
        logic start;
        logic neg;
    } t_exp_ctl;

endpackage

// File: rtl/galois_automorphism_permuter.sv
// Top level: Galois automorphism permuter over a coefficient store.
//
//  channel    | dir | handshake           | payload
//  -----------+-----+---------------------+---------------------------------------
//  s_axis     | in  | tvalid / tready     | tuser opcode; tdata position,coeff,rot
//  m_axis     | out | tvalid / tready     | tdata coeff_out, out_position
//  cfg        | in  | we (no wait)        | wdata log_size
//
//  Write word: stored at the accept edge.
//  Read word: latch, multiply j*e, store read, output load, the load held by
//  any stall on m_axis; the output register lets the next word be taken.
//  Select word: paced by the multiply-by-five unit.
//  Reset is synchronous, active low; the coefficient store is not cleared.
module galois_automorphism_permuter #(
    parameter int MAX_SIZE = gap_pkg::DEF_MAX_SIZE
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // [11:0] position, [75:12] coeff_in, [87:76] rotation
    input  logic [gap_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // [1:0] opcode
    input  logic [gap_pkg::OPCODE_W-1:0]   i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [63:0] coeff_out, [75:64] out_position, [79:76] zero
    output logic [gap_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [gap_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import gap_pkg::*;

    localparam int LOG_MAX = $clog2(MAX_SIZE + 1) - 1;
    localparam int AW      = LOG_MAX;
    localparam int EW      = LOG_MAX + 1;
    localparam int DEPTH   = 1 << LOG_MAX;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXP  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ADR  = 3'd3;
    localparam logic [2:0] ST_DATA = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [CFG_W-1:0]   r_log;
    logic [EW-1:0]      r_exp;
    logic [AW-1:0]      r_start;
    logic [AW-1:0]      r_pos;
    logic [AW-1:0]      r_prod;
    logic               r_out_valid;
    logic [COEFF_W-1:0] r_out_coeff;
    logic [POS_W-1:0]   r_out_pos;

    logic [CFG_W-1:0]   w_lg;
    logic [AW-1:0]      w_nmask;
    logic [EW-1:0]      w_tmask;
    logic [AW-1:0]      w_pos;
    logic [AW-1:0]      w_rot;
    logic               w_accept;
    logic               w_out_load;
    logic [AW+EW-1:0]   w_prod;
    logic [AW-1:0]      w_raddr;
    logic [COEFF_W-1:0] w_rdata;
    logic [EW:0]        w_half_up;
    t_exp_ctl           w_exp_ctl;
    logic               w_exp_done;
    logic [EW-1:0]      w_exp_val;

    // Clamp the size and build the index masks
    always_comb begin
        w_lg = r_log;
        if (r_log < LOG_SIZE_MIN) begin
            w_lg = LOG_SIZE_MIN;
        end else if (r_log > CFG_W'(LOG_MAX)) begin
            w_lg = CFG_W'(LOG_MAX);
        end
    end

    assign w_nmask = ~({AW{1'b1}} << w_lg);
    assign w_tmask = ~({EW{1'b1}} << (w_lg + CFG_W'(1)));

    // Reduce position and rotation to the size in use
    assign w_pos = AW'(i_s_axis_tdata[POS_W-1:0]) & w_nmask;
    assign w_rot = AW'(i_s_axis_tdata[IN_TDATA_W-1 -: ROT_W]) & w_nmask;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Rotations in the upper half use the negated power
    assign w_exp_ctl.start = w_accept && (i_s_axis_tuser == OP_SELECT);
    assign w_exp_ctl.neg   = (w_rot > (w_nmask >> 1));

    gap_exp #(
        .AW (AW),
        .EW (EW)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_exp_ctl),
        .i_count (w_rot & (w_nmask >> 1)),
        .i_tmask (w_tmask),
        .o_done  (w_exp_done),
        .o_exp   (w_exp_val)
    );

    // Source index = start + j*e, modulo N
    assign w_prod  = (AW+EW)'(r_pos) * (AW+EW)'(r_exp);
    assign w_raddr = (r_start + r_prod) & w_nmask;

    gap_ram #(
        .WIDTH (COEFF_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_s_axis_tuser == OP_WRITE)),
        .i_waddr (w_pos),
        .i_wdata (i_s_axis_tdata[POS_W +: COEFF_W]),
        .i_re    (r_state == ST_ADR),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_load = (r_state == ST_DATA) && (!r_out_valid || i_m_axis_tready);

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_s_axis_tuser == OP_SELECT)) begin
                    n_state = ST_EXP;
                end else if (w_accept && (i_s_axis_tuser == OP_READ)) begin
                    n_state = ST_MUL;
                end
            end
            ST_EXP: begin
                if (w_exp_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MUL:  n_state = ST_ADR;
            ST_ADR:  n_state = ST_DATA;
            ST_DATA: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Start offset (e+1)/2 - 1
    assign w_half_up = ({1'b0, w_exp_val} + (EW+1)'(1)) >> 1;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_log       <= LOG_SIZE_RST;
            r_exp       <= EW'(1);
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_log <= i_cfg_wdata;
            end
            if ((r_state == ST_EXP) && w_exp_done) begin
                r_exp   <= w_exp_val;
                r_start <= AW'(w_half_up - (EW+1)'(1));
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pos <= w_pos;
        end
        if (r_state == ST_MUL) begin
            r_prod <= w_prod[AW-1:0];
        end
        if (w_out_load) begin
            r_out_coeff <= w_rdata;
            r_out_pos   <= POS_W'(r_pos);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W-COEFF_W-POS_W)'(0), r_out_pos, r_out_coeff};

endmodule

// File: rtl/gap_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module gap_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/gap_exp.sv
// Exponent unit: iterated multiply-by-five modulo 2N, optional negation at the end.
module gap_exp #(
    parameter int AW = 12,
    parameter int EW = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gap_pkg::t_exp_ctl i_ctl,
    input  logic [AW-1:0]     i_count,
    input  logic [EW-1:0]     i_tmask,
    output logic              o_done,
    output logic [EW-1:0]     o_exp
);
    import gap_pkg::*;

    logic          r_busy;
    logic          r_done;
    logic          r_neg;
    logic [AW-1:0] r_cnt;
    logic [EW-1:0] r_g;
    logic [EW-1:0] r_tmask;
    logic [EW-1:0] r_exp;
    logic [EW-1:0] w_g5;

    // g * 5 as g + 4g, reduced by the power-of-two mask
    assign w_g5 = (r_g + (r_g << 2)) & r_tmask;

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: load, step, finish
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_g     <= EW'(1);
            r_cnt   <= i_count;
            r_neg   <= i_ctl.neg;
            r_tmask <= i_tmask;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_exp <= r_neg ? ((~r_g + EW'(1)) & r_tmask) : r_g;
            end else begin
                r_g   <= w_g5;
                r_cnt <= r_cnt - AW'(1);
            end
        end
    end

    assign o_done = r_done;
    assign o_exp  = r_exp;

endmodule

// File: rtl/gap_checker.sv
// Port checker for the automorphism permuter, bound to the top level.
`include "galois_automorphism_permuter_macros.svh"

module gap_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [gap_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic [gap_pkg::OPCODE_W-1:0]    i_s_axis_tuser,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [gap_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input logic                            i_cfg_we,
    input logic [gap_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import gap_pkg::*;

    logic w_in_word;
    logic w_out_stall;
    logic w_cfg_unused;

    assign w_in_word    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_stall  = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_cfg_unused = i_cfg_we && (i_cfg_wdata == '0) && (i_s_axis_tdata == '0);

    // Hold a stalled output word
    `GAP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_m_axis_tvalid, "output word dropped while stalled")
    `GAP_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_out_stall, $stable(o_m_axis_tdata), "stalled output word changed")

    // A store write finishes at once, the input stays open
    `GAP_ASSERT_NEXT(a_write_ready, i_clk, i_rst_n, w_in_word && (i_s_axis_tuser == OP_WRITE), o_s_axis_tready || w_cfg_unused, "input closed after a store write")

    // Reads and rotation selects keep the sequencer busy
    `GAP_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, w_in_word && ((i_s_axis_tuser == OP_READ) || (i_s_axis_tuser == OP_SELECT)), !o_s_axis_tready, "input open while a word is in work")

endmodule

bind galois_automorphism_permuter gap_checker u_gap_checker (.*);

// File: verif/tb.sv
// Testbench for the Galois automorphism permuter: directed table, random words, scoreboard.
`timescale 1ns / 1ps

module tb;
    import gap_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;
    localparam int MAX_LOG     = $clog2(DEF_MAX_SIZE);
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_WORDS  = 380;
    localparam int NUM_PHASES  = 8;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [OPCODE_W-1:0]    s_tuser = '0;
    logic                   m_ready = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata = '0;
    logic                   s_ready;
    logic                   m_valid;
    logic [OUT_TDATA_W-1:0] m_tdata;

    always #2 i_clk = ~i_clk;

    galois_automorphism_permuter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    // Mirror of the block state
    logic [COEFF_W-1:0] coeff_mem [DEF_MAX_SIZE];
    bit                 loaded [DEF_MAX_SIZE];
    logic [12:0]        auto_exp = 13'd1;
    logic [POS_W-1:0]   auto_start = '0;
    logic [CFG_W-1:0]   log_size_q = LOG_SIZE_RST;

    typedef struct packed {
        logic [COEFF_W-1:0] coeff;
        logic [POS_W-1:0]   pos;
    } permuted_t;

    permuted_t permuted_q[$];

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [POS_W-1:0]    pos;
        logic [COEFF_W-1:0]  coeff;
        logic [ROT_W-1:0]    rot;
        logic                typed;
        logic [COEFF_W-1:0]  want;
    } stim_row_t;

    int  err_cnt = 0;
    int  sent_cnt = 0;
    int  check_cnt = 0;
    int  select_cnt = 0;
    int  size_cnt = 0;
    bit  steady = 1'b0;
    bit  hold_req = 1'b0;

    // Vector length in use, with out-of-range settings clamped
    function automatic int vec_len();
        int lg = log_size_q;
        if (lg < LOG_SIZE_MIN) lg = LOG_SIZE_MIN;
        if (lg > MAX_LOG) lg = MAX_LOG;
        return 1 << lg;
    endfunction

    // Exponent 5^r mod 2N, negated for the upper half of rotations
    function automatic void select_rotation(logic [ROT_W-1:0] rot);
        int n = vec_len();
        int mask = 2 * n - 1;
        int r = rot & (n - 1);
        int g = 1;
        int steps;
        steps = (r < n / 2) ? r : r - n / 2;
        for (int i = 0; i < steps; i++) g = (g * 5) & mask;
        if (r >= n / 2) g = (2 * n - g) & mask;
        auto_exp = g[12:0];
        auto_start = 12'((g + 1) / 2 - 1);
    endfunction

    function automatic int source_index(logic [POS_W-1:0] pos);
        int n = vec_len();
        return (int'(auto_start) + int'(pos & 12'(n - 1)) * int'(auto_exp)) & (n - 1);
    endfunction

    // Update the mirror for one accepted word, queue the coefficient a read returns
    function automatic void predict_word(logic [OPCODE_W-1:0] op, logic [POS_W-1:0] pos,
                                         logic [COEFF_W-1:0] coeff, logic [ROT_W-1:0] rot,
                                         bit typed, logic [COEFF_W-1:0] want);
        int n = vec_len();
        logic [POS_W-1:0] p = pos & 12'(n - 1);
        permuted_t w;
        case (op)
            OP_WRITE: begin
                coeff_mem[p] = coeff;
                loaded[p] = 1'b1;
            end
            OP_SELECT: begin
                select_rotation(rot);
                select_cnt++;
            end
            OP_READ: begin
                w.coeff = typed ? want : coeff_mem[source_index(p)];
                w.pos = p;
                permuted_q.push_back(w);
            end
            default: ;
        endcase
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one word from a falling edge, hold it until accepted
    task automatic send_word(input logic [OPCODE_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic [COEFF_W-1:0] coeff, input logic [ROT_W-1:0] rot,
                             input bit typed = 1'b0, input logic [COEFF_W-1:0] want = '0);
        int g = steady ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_tdata <= {rot, coeff, pos};
        s_tuser <= op;
        do @(posedge i_clk); while (!s_ready);
        predict_word(op, pos, coeff, rot, typed, want);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    // Read a position, loading its source entry first if it was never written
    task automatic read_word(input logic [POS_W-1:0] pos, input bit typed = 1'b0,
                             input logic [COEFF_W-1:0] want = '0);
        int n = vec_len();
        int src = source_index(pos);
        if (!loaded[src])
            send_word(OP_WRITE, 12'(src) | (12'($urandom) & ~12'(n - 1)),
                      {$urandom, $urandom}, 12'($urandom));
        send_word(OP_READ, pos, {$urandom, $urandom}, 12'($urandom), typed, want);
    endtask

    // Wait for all reads to return, then for a select that may still be running
    task automatic drain();
        s_valid <= 1'b0;
        while (permuted_q.size() != 0) @(negedge i_clk);
        repeat (vec_len() / 2 + 8) @(negedge i_clk);
    endtask

    task automatic set_log_size(input logic [CFG_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        log_size_q = v;
        size_cnt++;
    endtask

    // Compare each returned word with the oldest expectation
    always @(posedge i_clk) begin
        permuted_t exp_w;
        if (i_rst_n && m_valid && m_ready) begin
            if (permuted_q.size() == 0) begin
                $error("unexpected output word %h", m_tdata);
                err_cnt++;
            end else begin
                exp_w = permuted_q.pop_front();
                check_cnt++;
                if (m_tdata[63:0] !== exp_w.coeff) begin
                    $error("coeff_out: expected %h, got %h", exp_w.coeff, m_tdata[63:0]);
                    err_cnt++;
                end
                if (m_tdata[75:64] !== exp_w.pos) begin
                    $error("out_position: expected %0d, got %0d", exp_w.pos, m_tdata[75:64]);
                    err_cnt++;
                end
                if (m_tdata[79:76] !== 4'd0) begin
                    $error("pad: expected 0, got %h", m_tdata[79:76]);
                    err_cnt++;
                end
            end
        end
    end

    // Output side: random stalls, one long hold-off on request
    initial begin
        int stall;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (steady || $urandom_range(0, 99) < 60) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                stall = gap_len();
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    // Stimulus
    initial begin
        stim_row_t rows [21];
        logic [CFG_W-1:0] sizes [NUM_PHASES];
        int k;

        // Directed rows at the reset size, N = 4096
        rows = '{
            '{OP_WRITE,  12'd0,    64'd0,                 12'd0,    1'b0, 64'd0},
            '{OP_WRITE,  12'd4095, '1,                    12'd4095, 1'b0, 64'd0},
            '{OP_WRITE,  12'd1,    64'h8000000000000001,  12'd0,    1'b0, 64'd0},
            '{OP_WRITE,  12'd4094, 64'h5555555555555555,  12'd0,    1'b0, 64'd0},
            '{OP_WRITE,  12'd2,    64'h0123456789abcdef,  12'd0,    1'b0, 64'd0},
            '{OP_READ,   12'd0,    64'd0,                 12'd0,    1'b1, 64'd0},
            '{OP_READ,   12'd4095, 64'd0,                 12'd0,    1'b1, '1},
            '{OP_SPARE,  12'd1,    64'hdeadbeefdeadbeef,  12'd5,    1'b0, 64'd0},
            '{OP_READ,   12'd1,    64'd0,                 12'd0,    1'b1, 64'h8000000000000001},
            '{OP_SELECT, 12'd0,    64'd0,                 12'd0,    1'b0, 64'd0},
            '{OP_READ,   12'd4094, 64'd0,                 12'd0,    1'b1, 64'h5555555555555555},
            '{OP_SELECT, 12'd0,    64'd0,                 12'd2048, 1'b0, 64'd0},
            '{OP_READ,   12'd0,    64'd0,                 12'd0,    1'b1, '1},
            '{OP_READ,   12'd1,    64'd0,                 12'd0,    1'b1, 64'h5555555555555555},
            '{OP_SELECT, 12'd0,    64'd0,                 12'd1,    1'b0, 64'd0},
            '{OP_READ,   12'd0,    64'd0,                 12'd0,    1'b1, 64'h0123456789abcdef},
            '{OP_SELECT, 12'd0,    64'd0,                 12'd4095, 1'b0, 64'd0},
            '{OP_READ,   12'd4095, 64'd0,                 12'd0,    1'b0, 64'd0},
            '{OP_READ,   12'd2048, 64'd0,                 12'd0,    1'b0, 64'd0},
            '{OP_WRITE,  12'd4095, 64'haaaaaaaaaaaaaaaa,  12'd0,    1'b0, 64'd0},
            '{OP_READ,   12'd0,    64'd0,                 12'd0,    1'b0, 64'd0}
        };
        sizes = '{4'd2, 4'd0, 4'd12, 4'd15, 4'd5, 4'd3, 4'd9, 4'($urandom_range(0, 15))};

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        foreach (rows[i]) begin
            if (rows[i].op == OP_READ)
                read_word(rows[i].pos, rows[i].typed, rows[i].want);
            else
                send_word(rows[i].op, rows[i].pos, rows[i].coeff, rows[i].rot);
        end

        // Random words over several size settings
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            set_log_size(sizes[ph]);
            steady = (ph == 2 || ph == 5);
            if (ph == 2) hold_req = 1'b1;
            for (int w = 0; w < RAND_WORDS / NUM_PHASES; w++) begin
                k = $urandom_range(0, 99);
                if (k < 3)
                    send_word(OP_SPARE, 12'($urandom), {$urandom, $urandom}, 12'($urandom));
                else if (k < 8)
                    send_word(OP_SELECT, 12'($urandom), {$urandom, $urandom}, 12'($urandom));
                else if (k < 30)
                    send_word(OP_WRITE, 12'($urandom), {$urandom, $urandom}, 12'($urandom));
                else
                    read_word(12'($urandom));
            end
        end
        steady = 1'b0;
        drain();

        $display("Sent %0d words (%0d rotation selects), checked %0d permuted coefficients,",
                 sent_cnt, select_cnt, check_cnt);
        $display("across %0d size settings incl. clamped extremes and a long output hold-off.",
                 size_cnt);
        if (err_cnt == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    // Hard limit on the run
    initial begin
        #4000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/gap_pkg.sv
rtl/gap_ram.sv
rtl/gap_exp.sv
rtl/galois_automorphism_permuter.sv
rtl/gap_checker.sv
verif/tb.sv
